// ----- sv/pidel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidel_pkg: shared types for the positional insert/delete array
// Command, status, controller state and per-cell operation codes, plus the
// control bundle that is broadcast to every storage cell.
// ----------------------------------------------------------------------------
package pidel_pkg;

    localparam int ValueW = 32;

    typedef enum logic [1:0] {
        CMD_DISPLAY = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_DELETE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [ValueW-1:0]  value;
    } t_cell_ctrl;

endpackage

// ----- sv/pidel_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidel_cell: one list entry
// Holds one value and, from the broadcast operation, position and count,
// decides whether to keep it, load the new value, or take a neighbor's value.
// ----------------------------------------------------------------------------
module pidel_cell
    import pidel_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CNT_W-1:0]          i_pos,
    input  logic [CNT_W-1:0]          i_count,
    input  logic signed [ValueW-1:0]  i_left,
    input  logic signed [ValueW-1:0]  i_right,
    input  logic signed [ValueW-1:0]  i_head,
    output logic signed [ValueW-1:0]  o_value
);

    localparam logic [CNT_W-1:0] CellIdx  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] CellNext = CNT_W'(IDX + 1);

    logic signed [ValueW-1:0] r_value;
    logic signed [ValueW-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_INSERT: begin
                // load at the insert point, move up from the left above it
                if (i_pos == CellIdx) begin
                    n_value = i_ctrl.value;
                end else if ((CellIdx > i_pos) && (CellIdx <= i_count)) begin
                    n_value = i_left;
                end
            end
            CELL_DELETE: begin
                if ((CellIdx >= i_pos) && (CellNext < i_count)) begin
                    n_value = i_right;
                end
            end
            CELL_ROTATE: begin
                // advance toward the head; the tail takes the old head
                if (CellNext < i_count) begin
                    n_value = i_right;
                end else if (CellNext == i_count) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- sv/positional_insert_delete_array.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array: ordered list with insert/delete at position
// A row of cells holds up to CAPACITY signed values; insert and delete move
// the affected cells by one place at once, display rotates the row
// through the head cell and emits one entry per cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ---------------------------------------------
//  command   start & !busy      i_cmd, i_position, i_new_value
//  result    o_valid (1 cycle)  o_status, o_entry_index, o_entry_value,
//                               o_entry_count, o_last
//
//  Insert and delete leave busy low: the status result appears in the cycle
//  after the transaction, so commands may follow back to back. Display holds
//  busy while the cell row rotates through cell 0, one rotation step per
//  emitted entry; each result appears in the cycle after its rotation step.
//  Display of an empty list gives one result. Reset (synchronous, active
//  low) clears the count and controller state; cell contents are not reset.
//  The receiver cannot stall results.
// ----------------------------------------------------------------------------
module positional_insert_delete_array
    import pidel_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_cmd,
    input  logic [4:0]                i_position,
    input  logic signed [ValueW-1:0]  i_new_value,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [3:0]                o_entry_index,
    output logic signed [ValueW-1:0]  o_entry_value,
    output logic [4:0]                o_entry_count,
    output logic                      o_last
);

    // count width holds 0..CAPACITY, index width 0..CAPACITY-1
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CmpW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    // ---------------- controller registers ----------------
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx,   n_idx;

    // result register
    logic                      r_valid,  n_valid;
    t_status                   r_status, n_status;
    logic [3:0]                r_index,  n_index;
    logic signed [ValueW-1:0]  r_value,  n_value;
    logic [4:0]                r_rcount, n_rcount;
    logic                      r_last,   n_last;

    // ---------------- cell row ----------------
    t_cell_ctrl                w_ctrl;
    logic [CW-1:0]             w_pos;
    logic signed [ValueW-1:0]  w_vals [CAPACITY];
    logic signed [ValueW-1:0]  w_head;

    logic                      w_accept;
    logic                      w_disp_last;
    logic [CmpW-1:0]           w_pos_ext;
    logic [CmpW-1:0]           w_cnt_ext;

    assign w_accept    = start && !busy;
    assign w_head      = w_vals[0];
    // the cells act on the position only once it is known to be in range
    assign w_pos       = CW'(i_position);
    assign w_pos_ext   = CmpW'(i_position);
    assign w_cnt_ext   = CmpW'(r_count);
    assign w_disp_last = ((CW'(r_idx) + CW'(1)) == r_count);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ValueW-1:0] w_left;
        logic signed [ValueW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_vals[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_vals[g+1];
        end

        pidel_cell #(
            .IDX   (g),
            .CNT_W (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_value (w_vals[g])
        );
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == CMD_DISPLAY) && (r_count != '0)) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (w_disp_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- outputs and cell control ----------------
    always_comb begin
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.value = i_new_value;
        n_count      = r_count;
        n_idx        = r_idx;
        n_valid      = 1'b0;
        n_status     = ST_OK;
        n_index      = '0;
        n_value      = '0;
        n_rcount     = 5'(r_count);
        n_last       = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    case (i_cmd)
                        CMD_DISPLAY: begin
                            // empty list: single result, otherwise rotate next
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (r_count == CapCount) begin
                                n_status = ST_FULL;
                            end else if (w_pos_ext > w_cnt_ext) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctrl.op = CELL_INSERT;
                                n_count   = r_count + CW'(1);
                                n_rcount  = 5'(n_count);
                            end
                        end
                        CMD_DELETE: begin
                            n_valid = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctrl.op = CELL_DELETE;
                                n_count   = r_count - CW'(1);
                                n_rcount  = 5'(n_count);
                            end
                        end
                        default: begin
                            // unused command code: drop it, no result
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DISP: begin
                // emit the head entry and rotate the row by one
                w_ctrl.op = CELL_ROTATE;
                n_valid   = 1'b1;
                n_index   = 4'(r_idx);
                n_value   = w_head;
                n_last    = w_disp_last;
                n_idx     = w_disp_last ? '0 : r_idx + IW'(1);
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_index  <= n_index;
        r_value  <= n_value;
        r_rcount <= n_rcount;
        r_last   <= n_last;
    end

    assign busy          = (r_state == S_DISP);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_index;
    assign o_entry_value = r_value;
    assign o_entry_count = r_rcount;
    assign o_last        = r_last;

    // ---------------- assertions ----------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("list count exceeds capacity");

    a_more_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final display result without display in progress");

    a_disp_ends_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_valid && o_last))
        else $error("display ended without a final result");

    a_insert_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK) && $past(i_rst_n)
            && $past(w_accept) && ($past(i_cmd) == CMD_INSERT))
        |-> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the list by one");

endmodule

// ----- tb/sv/positional_insert_delete_array_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array_tb: self-checking bench for the ordered list
// Feeds display, insert and delete commands (plus the unused code) through the
// start/busy handshake, keeps a golden copy of the list and its count, and
// checks every strobed result field by field against the expected stream.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_tb;
    import pidel_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_CMDS  = 385;          // counted commands in the random part
    localparam int QUIET_TAIL   = 80;           // last commands go out with no gaps
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

    // Code 3 has no command behind it; the block must swallow it silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [ValueW-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [ValueW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // One command transaction plus the idle cycles to insert ahead of it.
    typedef struct {
        logic [1:0]               cmd;
        logic [4:0]               position;
        logic signed [ValueW-1:0] value;
        int unsigned              gap;
    } t_list_cmd;

    // One strobed result as the block should present it.
    typedef struct {
        logic [1:0]               status;
        logic [3:0]               index;
        logic signed [ValueW-1:0] value;
        logic [4:0]               count;
        logic                     last;
    } t_list_result;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      start         = 1'b0;
    logic [1:0]                i_cmd         = CMD_DISPLAY;
    logic [4:0]                i_position    = '0;
    logic signed [ValueW-1:0]  i_new_value   = '0;
    logic                      busy;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic [3:0]                o_entry_index;
    logic signed [ValueW-1:0]  o_entry_value;
    logic [4:0]                o_entry_count;
    logic                      o_last;

    always #6 i_clk = ~i_clk;

    positional_insert_delete_array #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_list_cmd    pending_cmds[$];       // commands not yet handed to the driver
    t_list_result expected_results[$];   // results owed by the block, oldest first

    // Golden copy of the list. Only slots below golden_count are ever read.
    logic signed [ValueW-1:0] golden_entries [CAPACITY];
    int                       golden_count = 0;

    // Generator side: a count-only shadow so positions can be aimed at the
    // legal range, plus the gap shaping knobs.
    int gen_count = 0;
    int calm_left = 0;
    bit no_gaps   = 1'b0;

    int n_total      = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_mismatches = 0;
    int status_hits [4];

    task automatic report_mismatch(input string msg);
        n_mismatches++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic logic signed [ValueW-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Append a command, decide its lead-in gap and update the shadow count.
    function automatic void queue_cmd(input logic [1:0] cmd, input logic [4:0] pos,
                                      input logic signed [ValueW-1:0] val);
        t_list_cmd c;
        c.cmd      = cmd;
        c.position = pos;
        c.value    = val;
        c.gap      = 0;
        if (!no_gaps) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 15) == 0) begin
                // open a stretch of back-to-back commands
                calm_left = $urandom_range(8, 30);
            end else if ($urandom_range(0, 2) == 0) begin
                c.gap = $urandom_range(1, 3);
            end
        end
        if (cmd == CMD_INSERT && gen_count < CAPACITY && int'(pos) <= gen_count)
            gen_count++;
        else if (cmd == CMD_DELETE && int'(pos) < gen_count)
            gen_count--;
        pending_cmds.push_back(c);
    endfunction

    // ------------------------------------------------------------------------
    // Golden list: works out the results of one accepted command
    // ------------------------------------------------------------------------
    function automatic void owe_result(input logic [1:0] status, input int idx,
                                       input logic signed [ValueW-1:0] val,
                                       input int cnt, input logic last);
        t_list_result r;
        r.status = status;
        r.index  = idx[3:0];
        r.value  = val;
        r.count  = cnt[4:0];
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void apply_list_command(input t_list_cmd c);
        int i;
        int pos;
        pos = int'(c.position);
        case (c.cmd)
            CMD_DISPLAY: begin
                if (golden_count == 0) begin
                    owe_result(ST_EMPTY, 0, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < golden_count; i++)
                        owe_result(ST_OK, i, golden_entries[i], golden_count,
                                   i == golden_count - 1);
                end
            end
            CMD_INSERT: begin
                if (golden_count >= CAPACITY) begin
                    owe_result(ST_FULL, 0, '0, golden_count, 1'b1);
                end else if (pos > golden_count) begin
                    owe_result(ST_BADPOS, 0, '0, golden_count, 1'b1);
                end else begin
                    // open a hole at pos by moving the tail up one slot
                    for (i = golden_count; i > pos; i--)
                        golden_entries[i] = golden_entries[i - 1];
                    golden_entries[pos] = c.value;
                    golden_count++;
                    owe_result(ST_OK, 0, '0, golden_count, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (golden_count == 0) begin
                    owe_result(ST_EMPTY, 0, '0, 0, 1'b1);
                end else if (pos >= golden_count) begin
                    owe_result(ST_BADPOS, 0, '0, golden_count, 1'b1);
                end else begin
                    // close the gap by moving the tail down one slot
                    for (i = pos; i + 1 < golden_count; i++)
                        golden_entries[i] = golden_entries[i + 1];
                    golden_count--;
                    owe_result(ST_OK, 0, '0, golden_count, 1'b1);
                end
            end
            default: ;  // unused code: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command driver
    // A transaction completes at an edge where start is high and busy is low.
    // Predict it at that edge, then either present the next command right away
    // (start stays high) or drop start for its lead-in gap. While busy holds
    // the command off, keep start and the fields steady.
    // ------------------------------------------------------------------------
    t_list_cmd on_bus;
    t_list_cmd staged;
    bit        have_staged = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_list_command(on_bus);
                n_accepted++;
            end
            if (!start || !busy) begin
                if (!have_staged && pending_cmds.size() > 0) begin
                    staged      = pending_cmds.pop_front();
                    have_staged = 1'b1;
                end
                if (have_staged && staged.gap == 0) begin
                    on_bus      = staged;
                    have_staged = 1'b0;
                    i_cmd       <= staged.cmd;
                    i_position  <= staged.position;
                    i_new_value <= staged.value;
                    start       <= 1'b1;
                end else begin
                    // idle this cycle; count down the gap of the staged command
                    start <= 1'b0;
                    if (have_staged)
                        staged.gap--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // Each strobe lasts one cycle and cannot be stalled; take it at the edge
    // that ends that cycle and match it against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result status=%0d idx=%0d val=%0d cnt=%0d last=%0d",
                    o_status, o_entry_index, o_entry_value, o_entry_count, o_last));
            end else begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (o_status !== want.status || o_entry_index !== want.index ||
                    o_entry_value !== want.value || o_entry_count !== want.count ||
                    o_last !== want.last)
                    report_mismatch($sformatf({
                        "got status=%0d idx=%0d val=%0d cnt=%0d last=%0d, ",
                        "want %0d/%0d/%0d/%0d/%0d"},
                        o_status, o_entry_index, o_entry_value, o_entry_count, o_last,
                        want.status, want.index, want.value, want.count, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, drain and conclude
    // ------------------------------------------------------------------------
    initial begin
        int  k;
        int  n_random;
        int  roll;
        bit  grow;

        // Directed part: empty list corner cases first.
        queue_cmd(CMD_DISPLAY, 5'd0, '0);               // display of empty list
        queue_cmd(CMD_DELETE, 5'd0, '0);                // delete from empty list
        queue_cmd(CMD_INSERT, 5'd1, 32'sd7);            // insert beyond count
        queue_cmd(CMD_INSERT, 5'd0, VALUE_MIN);         // first entry
        queue_cmd(CMD_INSERT, 5'd1, VALUE_MAX);         // append at count
        queue_cmd(CMD_INSERT, 5'd1, '0);                // into the middle
        queue_cmd(CMD_INSERT, 5'd0, -1);                // at the head
        queue_cmd(CMD_DISPLAY, 5'd0, '0);
        queue_cmd(CMD_DELETE, 5'd4, '0);                // delete at count
        queue_cmd(CMD_DELETE, 5'd31, '0);               // delete far beyond count
        queue_cmd(CMD_UNUSED, 5'd31, -1);               // unused code, all ones
        queue_cmd(CMD_DELETE, 5'd1, '0);                // from the middle
        // Fill to capacity at random legal positions, then hit the full case.
        while (gen_count < CAPACITY)
            queue_cmd(CMD_INSERT, 5'($urandom_range(0, gen_count)), pick_value());
        queue_cmd(CMD_INSERT, 5'd0, 32'sd1);            // insert into full list
        queue_cmd(CMD_DISPLAY, 5'd0, '0);               // longest display
        queue_cmd(CMD_DELETE, 5'(CAPACITY - 1), '0);    // drop the tail

        // Random part. Swing between growing and shrinking runs so the list
        // walks its whole range, with some bad positions and stray codes.
        n_random = 0;
        grow     = 1'b1;
        for (k = 0; n_random < RANDOM_CMDS; k++) begin
            if (k % 37 == 0)
                grow = $urandom_range(0, 1);
            if (n_random >= RANDOM_CMDS - QUIET_TAIL)
                no_gaps = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                queue_cmd(CMD_UNUSED, 5'($urandom), pick_value());
            end else begin
                n_random++;
                if (roll < 18)
                    queue_cmd(CMD_DISPLAY, 5'($urandom), pick_value());
                else if (roll < 25)
                    queue_cmd(CMD_INSERT, 5'($urandom_range(gen_count + 1, 31)),
                              pick_value());
                else if (roll < 31)
                    queue_cmd(CMD_DELETE, 5'($urandom_range(gen_count, 31)),
                              pick_value());
                else if ($urandom_range(0, 9) < (grow ? 8 : 2))
                    queue_cmd(CMD_INSERT, 5'($urandom_range(0, gen_count)),
                              pick_value());
                else
                    queue_cmd(CMD_DELETE,
                              5'((gen_count == 0) ? 0 : $urandom_range(0, gen_count - 1)),
                              pick_value());
            end
        end
        queue_cmd(CMD_DISPLAY, 5'd0, '0);               // final contents check
        n_total = pending_cmds.size();

        // Hold reset low, then let the driver go.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d command transactions and %0d results", n_accepted, n_results);
        $display("Statuses seen: ok %0d, full %0d, bad position %0d, empty %0d",
                 status_hits[ST_OK], status_hits[ST_FULL],
                 status_hits[ST_BADPOS], status_hits[ST_EMPTY]);
        if (n_mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- positional_insert_delete_array.f -----
sv/pidel_pkg.sv
sv/pidel_cell.sv
sv/positional_insert_delete_array.sv
tb/sv/positional_insert_delete_array_tb.sv
